### src/hrfr_pkg.sv
`default_nettype none

package hrfr_pkg;

	localparam int HRFR_FRAME_LEN = 64;

	localparam int BYTE_W = 8;
	localparam int OFF_W  = 6;
	localparam int HDR_W  = 40;

	localparam logic [HDR_W-1:0]  HDR_RESET = 40'h2B4950442C;
	localparam logic [BYTE_W-1:0] BYTE_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0A;

	// Shortest fill that can carry a header plus its trailing bytes
	localparam int HDR_SPAN = 8;

	// A completed good frame handed from the front to the back
	typedef struct packed {
		logic valid;
		logic bank;
	} hrfr_push_t;

endpackage

`default_nettype wire

### src/hrfr_frame_buf.sv
`default_nettype none

module hrfr_frame_buf #(
	parameter int ADDR_W = 7
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [ADDR_W-1:0]         wr_addr,
	input  wire logic [hrfr_pkg::BYTE_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [ADDR_W-1:0]         rd_addr,
	output logic      [hrfr_pkg::BYTE_W-1:0] rd_data
);
	import hrfr_pkg::*;

	logic [BYTE_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/hrfr_front.sv
`default_nettype none

module hrfr_front #(
	parameter int FRAME_LEN = hrfr_pkg::HRFR_FRAME_LEN,
	parameter int AW        = $clog2(FRAME_LEN)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic [hrfr_pkg::HDR_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [hrfr_pkg::BYTE_W-1:0] in_byte,
	input  wire logic [1:0]                  bank_busy,
	output hrfr_pkg::hrfr_push_t             push,
	output logic                             wr_en,
	output logic [AW:0]                      wr_addr,
	output logic [hrfr_pkg::BYTE_W-1:0]      wr_data
);
	import hrfr_pkg::*;

	localparam int CW = $clog2(FRAME_LEN + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FRAME_LEN);
	localparam logic [CW-1:0] CNT_HDR  = CW'(HDR_SPAN);
	localparam logic [CW-1:0] CNT_TWO  = CW'(2);

	logic [HDR_W-1:0]  hdr_q;
	logic [CW-1:0]     cnt_q;
	logic              bank_q;
	logic [BYTE_W-1:0] hist_q [7];

	logic          accept;
	logic [CW-1:0] cnt_inc;
	logic          hdr_hit;
	logic          crlf;
	logic          full;
	logic          restart;

	assign in_ready = !bank_busy[bank_q];
	assign accept   = in_valid && in_ready;
	assign cnt_inc  = cnt_q + CW'(1);

	// oldest five of the last eight bytes against the header
	assign hdr_hit = (cnt_inc >= CNT_HDR)
		&& (hist_q[6] == hdr_q[39:32]) && (hist_q[5] == hdr_q[31:24])
		&& (hist_q[4] == hdr_q[23:16]) && (hist_q[3] == hdr_q[15:8])
		&& (hist_q[2] == hdr_q[7:0]);
	assign crlf    = (hist_q[0] == BYTE_CR) && (in_byte == BYTE_LF);
	assign full    = !hdr_hit && (cnt_inc == CNT_FULL);
	assign restart = hdr_hit || full
		|| ((cnt_inc >= CNT_TWO) && (cnt_inc < CNT_FULL) && crlf);

	assign wr_en   = accept;
	assign wr_addr = {bank_q, cnt_q[AW-1:0]};
	assign wr_data = in_byte;

	assign push.valid = accept && full && crlf;
	assign push.bank  = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= HDR_RESET;
			cnt_q  <= '0;
			bank_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hdr_q <= cfg_data;
			end
			if (accept) begin
				cnt_q <= restart ? '0 : cnt_inc;
				if (push.valid) begin
					bank_q <= !bank_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_q[0] <= in_byte;
			for (int i = 1; i < 7; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

endmodule

`default_nettype wire

### src/hrfr_back.sv
`default_nettype none

module hrfr_back #(
	parameter int FRAME_LEN = hrfr_pkg::HRFR_FRAME_LEN,
	parameter int AW        = $clog2(FRAME_LEN)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  hrfr_pkg::hrfr_push_t             push,
	output logic [1:0]                       bank_busy,
	output logic                             rd_en,
	output logic [AW:0]                      rd_addr,
	input  wire logic [hrfr_pkg::BYTE_W-1:0] rd_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [hrfr_pkg::BYTE_W-1:0]      out_byte,
	output logic [hrfr_pkg::OFF_W-1:0]       out_offset,
	output logic                             out_last
);
	import hrfr_pkg::*;

	localparam logic [AW-1:0] IDX_LAST = AW'(FRAME_LEN - 1);

	// pending frames, one slot per bank, drained in bank order
	logic [1:0]        pend_q;
	logic              rd_bank_q;
	logic [AW-1:0]     idx_q;
	logic              valid_s1;
	logic [OFF_W-1:0]  off_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic [OFF_W-1:0]  off_q;
	logic              last_q;

	logic       out_free;
	logic       adv_s1;
	logic       issue;
	logic       idx_end;
	logic [1:0] set_mask;
	logic [1:0] clr_mask;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign issue    = pend_q[rd_bank_q] && (!valid_s1 || adv_s1);
	assign idx_end  = (idx_q == IDX_LAST);

	assign set_mask = push.valid ? (push.bank ? 2'b10 : 2'b01) : 2'b00;
	assign clr_mask = (issue && idx_end) ? (rd_bank_q ? 2'b10 : 2'b01) : 2'b00;

	assign bank_busy = pend_q;
	assign rd_en     = issue;
	assign rd_addr   = {rd_bank_q, idx_q};

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign out_offset = off_q;
	assign out_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			rd_bank_q   <= 1'b0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= (pend_q | set_mask) & ~clr_mask;
			if (issue) begin
				if (idx_end) begin
					idx_q     <= '0;
					rd_bank_q <= !rd_bank_q;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			off_s1  <= OFF_W'(idx_q);
			last_s1 <= idx_end;
		end
		if (adv_s1) begin
			byte_q <= rd_data;
			off_q  <= off_s1;
			last_q <= last_s1;
		end
	end

endmodule

`default_nettype wire

### src/header_resync_frame_receiver_unit.sv
`default_nettype none

// Frame receiver for a byte stream from a serial link.
// s_axis: one received byte per transaction (tdata[7:0]).
// cfg: writes the 40-bit header pattern, first header byte in bits 39:32.
//   Write only while no frame is being received or read out.
// m_axis: one frame byte per transaction, tdata[7:0] byte, tdata[13:8] offset,
//   tlast on the final byte of the frame.
// A byte is taken every cycle while the filling bank is free. Each byte lands
// in one of two frame banks; a header match, a CR LF inside the frame, or a
// full frame restarts the fill. A full frame ending in CR LF is queued and its
// bank handed to the readout. The first frame byte reaches m_axis through the
// queued-bank flag, the bank read port and the read-data register, then one
// byte per cycle while m_axis accepts, FRAME_LEN transactions in all.
// When m_axis stalls, the readout holds; s_axis keeps taking bytes into the
// other bank and drops tready only when both banks hold frames still waiting.
// Reset clears the fill count, the queued frames and the output, and loads
// the default header pattern. Bank contents are not cleared.
module header_resync_frame_receiver_unit #(
	parameter int FRAME_LEN = hrfr_pkg::HRFR_FRAME_LEN
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hrfr_pkg::HDR_W-1:0]  cfg_data,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [15:0]                      m_axis_tdata,  // [7:0] frame_byte,
	                                                        // [13:8] byte_offset
	output logic                             m_axis_tlast   // last_of_frame
);
	import hrfr_pkg::*;

	localparam int AW = $clog2(FRAME_LEN);

	hrfr_push_t        push;
	logic [1:0]        bank_busy;
	logic              wr_en;
	logic [AW:0]       wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW:0]       rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] out_byte;
	logic [OFF_W-1:0]  out_offset;

	assign cfg_ready = 1'b1;

	hrfr_front #(.FRAME_LEN(FRAME_LEN), .AW(AW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.bank_busy (bank_busy),
		.push      (push),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	hrfr_frame_buf #(.ADDR_W(AW + 1)) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hrfr_back #(.FRAME_LEN(FRAME_LEN), .AW(AW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.bank_busy  (bank_busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.out_offset (out_offset),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_offset, out_byte};

	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(FRAME_LEN - 1);

	a_last_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> out_offset == OFF_LAST)
		else $error("tlast on a byte that is not the final frame position");

	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		!m_axis_tvalid || out_offset == $past(out_offset) + OFF_W'(1))
		else $error("frame byte offsets out of sequence");

	a_push_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !bank_busy[push.bank])
		else $error("frame queued into a bank still waiting for readout");

endmodule

`default_nettype wire
